### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(lbl, clk_s, rst_s, ant, con) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ant) |-> (con)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk_s, rst_s, ant, con) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ant) |=> (con)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk_s, rst_s, ant, con)

`define ASSERT_NEXT(lbl, clk_s, rst_s, ant, con)

`endif

`endif

### rtl/core/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// shared types and constants of the duration literal parser
// ----------------------------------------------------------------------------
package dlp_pkg;

    localparam int CH_W    = 8;
    localparam int SECS_W  = 63;
    localparam int SCALE_W = 17;
    localparam int PROD_W  = SECS_W + SCALE_W;
    localparam int DSUM_W  = SECS_W + 4;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_S     = 8'h73;
    localparam logic [CH_W-1:0] CH_M     = 8'h6D;
    localparam logic [CH_W-1:0] CH_H     = 8'h68;
    localparam logic [CH_W-1:0] CH_D     = 8'h64;

    localparam logic [SCALE_W-1:0] SCALE_M = 17'd60;
    localparam logic [SCALE_W-1:0] SCALE_H = 17'd3600;
    localparam logic [SCALE_W-1:0] SCALE_D = 17'd86400;

    typedef enum logic [1:0] {
        PH_START,
        PH_AFTER_UNIT,
        PH_DIGITS,
        PH_SWALLOW
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EMPTY,
        ST_NEGATIVE,
        ST_SYNTAX,
        ST_UNIT,
        ST_OVERFLOW
    } status_t;

    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] ch;
        logic            end_mark;
    } item_t;

    typedef struct packed {
        logic              hit;
        status_t           status;
        logic [SECS_W-1:0] seconds;
    } result_t;

endpackage

### rtl/core/dlp_in_stage.sv
// ----------------------------------------------------------------------------
// dlp_in_stage
// input register holding one character word until the parser takes it
// ----------------------------------------------------------------------------
module dlp_in_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [dlp_pkg::CH_W-1:0] ch,
    input  logic                     end_mark,
    input  logic                     advance,
    output dlp_pkg::item_t           item
);
    import dlp_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    logic [CH_W-1:0] ch_reg;
    logic            end_mark_reg;

    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg       <= ch;
            end_mark_reg <= end_mark;
        end
    end

    assign item.valid    = valid_reg;
    assign item.ch       = ch_reg;
    assign item.end_mark = end_mark_reg;

endmodule

### rtl/core/dlp_core.sv
// ----------------------------------------------------------------------------
// dlp_core
// parser state and one-character step: digit accumulate, unit scale and sum
// ----------------------------------------------------------------------------
module dlp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dlp_pkg::item_t   item,
    output dlp_pkg::result_t res,
    output dlp_pkg::phase_t  phase
);
    import dlp_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [SECS_W-1:0]   tot_reg;
    logic [SECS_W-1:0]   tot_next;
    logic [SECS_W-1:0]   dv_reg;
    logic [SECS_W-1:0]   dv_next;
    logic                seen_reg;
    logic                seen_next;

    logic                is_digit;
    logic [3:0]          dgt;
    logic [DSUM_W-1:0]   dsum;
    logic                dsum_ovf;
    logic [PROD_W-1:0]   dv_wide;
    logic [PROD_W-1:0]   prod;
    logic                unit_ok;
    logic                prod_ovf;
    logic [SECS_W:0]     sum;
    logic                sum_ovf;
    logic                seg_ok;

    // decode and arithmetic
    assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign dgt      = item.ch[3:0];
    assign dsum     = {1'b0, dv_reg, 3'b000} + {3'b000, dv_reg, 1'b0} + DSUM_W'(dgt);
    assign dsum_ovf = |dsum[DSUM_W-1:SECS_W];
    assign dv_wide  = {{SCALE_W{1'b0}}, dv_reg};

    always_comb
    begin
        unit_ok = 1'b1;
        unique case (item.ch)
            CH_S:    prod = dv_wide;
            CH_M:    prod = dv_wide * PROD_W'(SCALE_M);
            CH_H:    prod = dv_wide * PROD_W'(SCALE_H);
            CH_D:    prod = dv_wide * PROD_W'(SCALE_D);
            default:
            begin
                prod    = '0;
                unit_ok = 1'b0;
            end
        endcase
    end

    assign prod_ovf = |prod[PROD_W-1:SECS_W];
    assign sum      = {1'b0, tot_reg} + {1'b0, prod[SECS_W-1:0]};
    assign sum_ovf  = sum[SECS_W];
    assign seg_ok   = unit_ok && !prod_ovf && !sum_ovf;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (item.end_mark)
        begin
            phase_next = PH_START;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (item.ch == CH_MINUS || !is_digit)
                        phase_next = PH_SWALLOW;
                    else
                        phase_next = PH_DIGITS;
                end
                PH_AFTER_UNIT:
                begin
                    phase_next = is_digit ? PH_DIGITS : PH_SWALLOW;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                        phase_next = dsum_ovf ? PH_SWALLOW : PH_DIGITS;
                    else
                        phase_next = seg_ok ? PH_AFTER_UNIT : PH_SWALLOW;
                end
                PH_SWALLOW:
                begin
                    phase_next = PH_SWALLOW;
                end
            endcase
        end
    end

    // verdict and datapath
    always_comb
    begin
        res.hit     = 1'b0;
        res.status  = ST_OK;
        res.seconds = '0;
        tot_next    = tot_reg;
        dv_next     = dv_reg;
        seen_next   = seen_reg;
        if (item.end_mark)
        begin
            tot_next  = '0;
            dv_next   = '0;
            seen_next = 1'b0;
            unique case (phase_reg)
                PH_START:
                begin
                    res.hit    = 1'b1;
                    res.status = ST_EMPTY;
                end
                PH_AFTER_UNIT:
                begin
                    res.hit = 1'b1;
                    if (seen_reg)
                        res.seconds = tot_reg;
                    else
                        res.status = ST_EMPTY;
                end
                PH_DIGITS:
                begin
                    res.hit = 1'b1;
                    if (seen_reg)
                        res.status = ST_SYNTAX;
                    else
                        res.seconds = dv_reg;
                end
                PH_SWALLOW:
                begin
                    res.hit = 1'b0;
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_START, PH_AFTER_UNIT:
                begin
                    if (phase_reg == PH_START && item.ch == CH_MINUS)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_NEGATIVE;
                    end
                    else if (!is_digit)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_SYNTAX;
                    end
                    else
                    begin
                        dv_next = SECS_W'(dgt);
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (dsum_ovf)
                        begin
                            res.hit    = 1'b1;
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            dv_next = dsum[SECS_W-1:0];
                        end
                    end
                    else if (!unit_ok)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_UNIT;
                    end
                    else if (prod_ovf || sum_ovf)
                    begin
                        res.hit    = 1'b1;
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        tot_next  = sum[SECS_W-1:0];
                        dv_next   = '0;
                        seen_next = 1'b1;
                    end
                end
                PH_SWALLOW:
                begin
                    res.hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            tot_reg   <= '0;
            dv_reg    <= '0;
            seen_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tot_reg   <= tot_next;
            dv_reg    <= dv_next;
            seen_reg  <= seen_next;
        end
    end

    assign phase = phase_reg;

endmodule

### rtl/core/dlp_out_stage.sv
// ----------------------------------------------------------------------------
// dlp_out_stage
// result register holding one verdict word until the sink takes it
// ----------------------------------------------------------------------------
module dlp_out_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  dlp_pkg::result_t           res,
    output logic                       free,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [dlp_pkg::SECS_W-1:0] seconds
);
    import dlp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              load;
    status_t           status_reg;
    logic [SECS_W-1:0] seconds_reg;

    assign free       = !valid_reg || !out_stall;
    assign load       = advance && res.hit;
    assign valid_next = free ? load : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= res.status;
            seconds_reg <= res.seconds;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign seconds   = seconds_reg;

endmodule

### rtl/core/duration_literal_parser_top.sv
// verdicts are registered, shown in the cycle after the causing word is taken
// throughput: one character word per cycle while the output is not stalled
// rate is set by the single parser step (digit accumulate or unit scale and sum)
// reset: asynchronous, clears both valid flags and returns the parser to the
// start of a literal with zero sums
// ----------------------------------------------------------------------------
// duration_literal_parser_top
// streaming parser of duration literals giving one status and seconds verdict
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module duration_literal_parser_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dlp_pkg::CH_W-1:0]   ch,
    input  logic                       end_mark,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [dlp_pkg::SECS_W-1:0] seconds
);
    import dlp_pkg::*;

    item_t   item;
    result_t res;
    phase_t  phase;
    logic    out_free;
    logic    advance;

    assign advance = item.valid && out_free;

    dlp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .end_mark (end_mark),
        .advance  (advance),
        .item     (item)
    );

    dlp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item),
        .res   (res),
        .phase (phase)
    );

    dlp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .seconds   (seconds)
    );

    `ASSERT_SAME(a_err_zero_secs, clk, rst_n, out_valid && status != ST_OK, seconds == '0)
    `ASSERT_NEXT(a_end_clears, clk, rst_n, advance && item.end_mark, phase == PH_START)
    `ASSERT_SAME(a_swallow_quiet, clk, rst_n, advance && !item.end_mark && phase == PH_SWALLOW, !res.hit)

endmodule

### sim/tb_duration_literal_parser_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_duration_literal_parser_top
// Feeds duration literals one character word at a time. A local parser
// computes each verdict as its word is taken, and the monitor compares every
// verdict from the block field by field. Directed literals cover the
// boundaries and each error case. Random literals, mostly well formed, follow.
// Both sides idle at random; there is one long output hold-off, and the feed
// pauses until the block has drained before the random literals and again later.
// ----------------------------------------------------------------------------
module tb_duration_literal_parser_top;

    import dlp_pkg::*;

    localparam logic [63:0] DUR_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        bit [7:0] ch;
        bit       end_mark;
        bit       pause;
    } word_t;

    typedef struct {
        status_t   st;
        bit [62:0] secs;
    } verdict_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [CH_W-1:0]   ch        = '0;
    logic              end_mark  = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [2:0]        status;
    logic [SECS_W-1:0] seconds;

    word_t    char_feed[$];
    verdict_t verdicts_due[$];
    bit       pause_next  = 1'b0;
    int       errors      = 0;
    int       words_taken = 0;
    int       gap_left    = 0;
    int       stall_left  = 0;
    bit       long_done   = 1'b0;
    logic [31:0] cyc      = '0;
    logic     calm;

    // parser state of the literal in progress
    bit [63:0] run_total;
    bit [63:0] run_digits;
    phase_t    run_phase = PH_START;
    bit        run_seen;

    duration_literal_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .end_mark  (end_mark),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .seconds   (seconds)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    assign calm = (cyc[9:7] == 3'd0);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_verdict(input status_t st, input bit [63:0] secs);
        verdict_t v;
        v.st   = st;
        v.secs = (st == ST_OK) ? secs[62:0] : 63'd0;
        verdicts_due.push_back(v);
    endtask

    task automatic parse_char(input bit [7:0] c, input bit e);
        bit        is_dig;
        bit [63:0] d;
        bit [63:0] scale;
        bit [63:0] prod;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d      = is_dig ? {56'd0, c - CH_ZERO} : 64'd0;
        if (e)
        begin
            case (run_phase)
                PH_START:      note_verdict(ST_EMPTY, 0);
                PH_AFTER_UNIT: note_verdict(run_seen ? ST_OK : ST_EMPTY, run_total);
                PH_DIGITS:     note_verdict(run_seen ? ST_SYNTAX : ST_OK, run_digits);
                default:       ;
            endcase
            run_total  = 0;
            run_digits = 0;
            run_phase  = PH_START;
            run_seen   = 1'b0;
        end
        else if (run_phase == PH_START && c == CH_MINUS)
        begin
            run_phase = PH_SWALLOW;
            note_verdict(ST_NEGATIVE, 0);
        end
        else if (run_phase == PH_START || run_phase == PH_AFTER_UNIT)
        begin
            if (!is_dig)
            begin
                run_phase = PH_SWALLOW;
                note_verdict(ST_SYNTAX, 0);
            end
            else
            begin
                run_digits = d;
                run_phase  = PH_DIGITS;
            end
        end
        else if (run_phase == PH_DIGITS)
        begin
            if (is_dig)
            begin
                if (run_digits > (DUR_MAX - d) / 10)
                begin
                    run_phase = PH_SWALLOW;
                    note_verdict(ST_OVERFLOW, 0);
                end
                else
                    run_digits = run_digits * 10 + d;
            end
            else
            begin
                case (c)
                    CH_S:    scale = 64'd1;
                    CH_M:    scale = 64'd60;
                    CH_H:    scale = 64'd3600;
                    CH_D:    scale = 64'd86400;
                    default: scale = 64'd0;
                endcase
                if (scale == 0)
                begin
                    run_phase = PH_SWALLOW;
                    note_verdict(ST_UNIT, 0);
                end
                else if (run_digits > DUR_MAX / scale)
                begin
                    run_phase = PH_SWALLOW;
                    note_verdict(ST_OVERFLOW, 0);
                end
                else
                begin
                    prod = run_digits * scale;
                    if (prod > DUR_MAX - run_total)
                    begin
                        run_phase = PH_SWALLOW;
                        note_verdict(ST_OVERFLOW, 0);
                    end
                    else
                    begin
                        run_total  = run_total + prod;
                        run_digits = 0;
                        run_seen   = 1'b1;
                        run_phase  = PH_AFTER_UNIT;
                    end
                end
            end
        end
    endtask

    task automatic add_byte(input bit [7:0] b);
        word_t w;
        w.ch       = b;
        w.end_mark = 1'b0;
        w.pause    = pause_next;
        pause_next = 1'b0;
        char_feed.push_back(w);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_end();
        word_t w;
        w.ch       = 8'($urandom);
        w.end_mark = 1'b1;
        w.pause    = pause_next;
        pause_next = 1'b0;
        char_feed.push_back(w);
    endtask

    function automatic string num_text();
        int        r;
        int        n;
        bit [63:0] v;
        string     s;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            v = $urandom_range(0, 99999);
            return $sformatf("%0d", v);
        end
        if (r < 80)
            return $sformatf("00%0d", $urandom_range(0, 99));
        if (r < 92)
        begin
            v = {$urandom, $urandom} >> $urandom_range(1, 63);
            return $sformatf("%0d", v);
        end
        s = "";
        n = $urandom_range(18, 21);
        for (int i = 0; i < n; i++)
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        return s;
    endfunction

    function automatic bit [7:0] unit_char();
        case ($urandom_range(0, 3))
            0:       return CH_S;
            1:       return CH_M;
            2:       return CH_H;
            default: return CH_D;
        endcase
    endfunction

    function automatic bit [7:0] bad_unit_char();
        bit [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_S || b == CH_M ||
               b == CH_H || b == CH_D);
        return b;
    endfunction

    task automatic add_random_literal();
        int        r;
        int        n;
        bit [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                add_text(num_text());
                add_byte(unit_char());
            end
            if ($urandom_range(0, 9) == 0)
                add_text(num_text());
        end
        else if (r < 70)
            add_text(num_text());
        else if (r < 78)
        begin
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom));
        end
        else if (r < 84)
        begin
            add_byte(CH_MINUS);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom));
        end
        else if (r < 90)
        begin
            add_text(num_text());
            add_byte(bad_unit_char());
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom));
        end
        else if (r < 95)
        begin
            v = 64'h4000_0000_0000_0000 + {$urandom, $urandom} % 64'h1000_0000_0000_0000;
            add_text($sformatf("%0ds", v));
            v = 64'h3800_0000_0000_0000 + {$urandom, $urandom} % 64'h1000_0000_0000_0000;
            add_text($sformatf("%0ds", v));
        end
        else
        begin
            add_text(num_text());
            add_byte(unit_char());
            add_byte(($urandom_range(0, 1) == 0) ? unit_char() : 8'($urandom));
        end
        add_end();
    endtask

    initial
    begin
        add_end();
        add_text("-5s");                   add_end();
        add_text("0");                     add_end();
        add_text("1d2h3m4s");              add_end();
        add_text("5s5s");                  add_end();
        add_text("5s7");                   add_end();
        add_text("7q3");                   add_end();
        add_text("x1");                    add_end();
        add_byte(8'h00);                   add_end();
        add_text("4");  add_byte(8'hFF);   add_end();
        add_text("2hm");                   add_end();
        add_text("9223372036854775807");   add_end();
        add_text("9223372036854775808");   add_end();
        add_text("9223372036854775807s");  add_end();
        add_text("106751991167300d");      add_end();
        add_text("106751991167301d");      add_end();
        add_text("9223372036854775807s1s"); add_end();
        pause_next = 1'b1;
        while (char_feed.size() < 1800)
        begin
            if (char_feed.size() > 1100 && char_feed.size() < 1120)
                pause_next = 1'b1;
            add_random_literal();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (char_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb_duration_literal_parser_top: clean");
        else
            $display("tb_duration_literal_parser_top: errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_duration_literal_parser_top: errors");
        $finish;
    end

    // character feed
    always @(posedge clk or negedge rst_n)
    begin : feed_drv
        word_t w;
        logic  took;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                parse_char(ch, end_mark);
                words_taken <= words_taken + 1;
            end
            if (in_valid && !took)
                ;
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (char_feed.size() != 0 &&
                     !(char_feed[0].pause && verdicts_due.size() != 0))
            begin
                w = char_feed.pop_front();
                ch       <= w.ch;
                end_mark <= w.end_mark;
                in_valid <= 1'b1;
                gap_left <= calm ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (!long_done && words_taken >= 700)
        begin
            out_stall  <= 1'b1;
            stall_left <= 400;
            long_done  <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            out_stall  <= ($urandom_range(0, 99) < 30);
            stall_left <= pick_gap();
        end
    end

    // verdict monitor
    always @(posedge clk)
    begin : verdict_mon
        verdict_t v;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict status %0d seconds %0d",
                         $time, status, seconds);
                errors++;
            end
            else
            begin
                v = verdicts_due.pop_front();
                if (status !== v.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, v.st, status);
                    errors++;
                end
                if (seconds !== v.secs)
                begin
                    $display("%0t: seconds expected %0d actual %0d",
                             $time, v.secs, seconds);
                    errors++;
                end
            end
        end
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/dlp_pkg.sv
rtl/core/dlp_in_stage.sv
rtl/core/dlp_core.sv
rtl/core/dlp_out_stage.sv
rtl/core/duration_literal_parser_top.sv
sim/tb_duration_literal_parser_top.sv
